// ===== hw/rtl/pfar_pkg.sv =====
// Shared constants, types and codes for the polyphase arbitrary resampler.
`default_nettype none
package pfar_pkg;
	localparam int ARMS         = 32;
	localparam int TAPS_PER_ARM = 32;
	localparam int TAP_WORDS    = ARMS * TAPS_PER_ARM;
	localparam int ARM_W        = $clog2(ARMS);
	localparam int POS_W        = $clog2(TAPS_PER_ARM);
	localparam int TADDR_W      = $clog2(TAP_WORDS);
	localparam int ACC_W        = 32 + POS_W;
	localparam int IDX_W        = ARM_W + 2;
	localparam int Y_W          = ACC_W + 17;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_ARM    = 2'd1,
		KIND_SLOPE  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_DEC_STEP   = 2'd0,
		REG_FRAC_STEP  = 2'd1,
		REG_START_ARM  = 2'd2,
		REG_START_FRAC = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRN1,
		ST_DRN2,
		ST_FIN1,
		ST_FIN2
	} state_t;

	typedef struct packed {
		logic vld;
		logic clr;
	} mac_ctl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/pfar_mac.sv =====
// Shared four-lane multiply-accumulate unit for arm and slope dot products.
`default_nettype none
module pfar_mac import pfar_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mac_ctl_t                ctl,
	input  wire logic signed [15:0]      x_i,
	input  wire logic signed [15:0]      x_q,
	input  wire logic signed [15:0]      ta,
	input  wire logic signed [15:0]      ts,
	output logic signed [ACC_W-1:0]      acc_ai,
	output logic signed [ACC_W-1:0]      acc_aq,
	output logic signed [ACC_W-1:0]      acc_si,
	output logic signed [ACC_W-1:0]      acc_sq,
	output logic                         busy
);
	logic signed [31:0] p_ai_s1, p_aq_s1, p_si_s1, p_sq_s1;
	logic               vld_s1, vld_s2;
	logic signed [ACC_W-1:0] ai_q, aq_q, si_q, sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_ai_s1 <= x_i * ta;
		p_aq_s1 <= x_q * ta;
		p_si_s1 <= x_i * ts;
		p_sq_s1 <= x_q * ts;
		if (ctl.clr) begin
			ai_q <= '0;
			aq_q <= '0;
			si_q <= '0;
			sq_q <= '0;
		end else if (vld_s2) begin
			ai_q <= ai_q + ACC_W'(p_ai_s1);
			aq_q <= aq_q + ACC_W'(p_aq_s1);
			si_q <= si_q + ACC_W'(p_si_s1);
			sq_q <= sq_q + ACC_W'(p_sq_s1);
		end
	end

	assign acc_ai = ai_q;
	assign acc_aq = aq_q;
	assign acc_si = si_q;
	assign acc_sq = sq_q;
	assign busy   = vld_s1 | vld_s2;
endmodule
`default_nettype wire

// ===== hw/rtl/polyphase_arbitrary_resampler_core.sv =====
// Top level of the polyphase arbitrary resampler: registers, tap memories, sequencer.
// Tap loads, ignored items and skipped samples are accepted in ST_IDLE and start no run.
// A sample that yields N outputs runs, for each output, a MAC pass over the 32 taps of an arm, the
// drain states ST_DRN1, ST_DRN2 and combine states ST_FIN1, ST_FIN2; N is at most 32.
// The single four-lane MAC unit walks one tap per cycle and sets the rate.
// Reset clears history, arm/fraction/skip state and registers (DEC_STEP to 1), not tap memories.
`default_nettype none
module polyphase_arbitrary_resampler_core import pfar_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic signed [15:0] sample_i,
	input  wire logic signed [15:0] sample_q,
	input  wire logic [9:0]         tap_index,
	input  wire logic signed [15:0] tap_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      out_i,
	output logic signed [15:0]      out_q,
	output logic                    run_last
);
	logic [5:0]  dec_step_q;
	logic [15:0] frac_step_q, start_frac_q;
	logic [4:0]  start_arm_q;
	logic [ARM_W-1:0] arm_idx_q;
	logic [15:0] frac_q;
	logic [5:0]  skip_q;
	logic [31:0] hist_q [TAPS_PER_ARM];
	logic [15:0] arm_mem [TAP_WORDS];
	logic [15:0] slope_mem [TAP_WORDS];
	logic [15:0] ta_s1, ts_s1;
	logic [31:0] hx_s1;
	logic [POS_W-1:0] pos_q;
	state_t state_q, state_d;
	logic [IDX_W-1:0] nxt_idx_q;
	logic [15:0] nxt_frac_q;
	logic last_q;
	logic signed [34:0] lo_i_q, lo_q_q;
	logic signed [35:0] hi_i_q, hi_q_q;
	logic signed [ACC_W-1:0] acc_ai, acc_aq, acc_si, acc_sq;
	logic mac_busy;
	mac_ctl_t mac_ctl;
	logic wr_en, acc_in, start_run, skip_dec, load_out;
	logic [TADDR_W-1:0] rd_addr;
	logic [16:0] frac_sum;
	logic [IDX_W-1:0] step, nxt_idx;
	logic signed [Y_W-1:0] y_i, y_q;
	logic [15:0] r_i, r_q;

	function automatic logic [15:0] rnd_sat(input logic signed [Y_W-1:0] y);
		logic signed [Y_W-1:0] b;
		logic signed [Y_W-32:0] s;
		b = y + (Y_W'(1) <<< 30);
		s = (Y_W-31)'(b >>> 31);
		if (s > (Y_W-31)'(32767)) begin
			rnd_sat = 16'h7fff;
		end else if (s < -(Y_W-31)'(32768)) begin
			rnd_sat = 16'h8000;
		end else begin
			rnd_sat = s[15:0];
		end
	endfunction

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign acc_in = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign start_run = acc_in && (kind_t'(kind) == KIND_SAMPLE) && (skip_q == '0);
	assign skip_dec  = acc_in && (kind_t'(kind) == KIND_SAMPLE) && (skip_q != '0);
	assign load_out  = (state_q == ST_FIN2) && (!out_valid || out_ready);

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_DEC_STEP:   prdata = {26'd0, dec_step_q};
			REG_FRAC_STEP:  prdata = {16'd0, frac_step_q};
			REG_START_ARM:  prdata = {27'd0, start_arm_q};
			REG_START_FRAC: prdata = {16'd0, start_frac_q};
			default:        prdata = '0;
		endcase
	end

	assign frac_sum = {1'b0, frac_q} + {1'b0, frac_step_q};
	assign step     = (dec_step_q == '0) ? IDX_W'(1) : IDX_W'(dec_step_q);
	assign nxt_idx  = IDX_W'(arm_idx_q) + step + IDX_W'(frac_sum[16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_step_q   <= 6'd1;
			frac_step_q  <= '0;
			start_arm_q  <= '0;
			start_frac_q <= '0;
			arm_idx_q    <= '0;
			frac_q       <= '0;
			skip_q       <= '0;
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			out_valid    <= 1'b0;
			for (int k = 0; k < TAPS_PER_ARM; k++) begin
				hist_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				unique case (reg_idx_t'(paddr[3:2]))
					REG_DEC_STEP:  dec_step_q <= pwdata[5:0];
					REG_FRAC_STEP: frac_step_q <= pwdata[15:0];
					REG_START_ARM: begin
						start_arm_q <= pwdata[4:0];
						arm_idx_q   <= ARM_W'(pwdata[4:0]);
						skip_q      <= '0;
					end
					REG_START_FRAC: begin
						start_frac_q <= pwdata[15:0];
						frac_q       <= pwdata[15:0];
					end
					default: ;
				endcase
			end
			if (acc_in && (kind_t'(kind) == KIND_SAMPLE)) begin
				hist_q[0] <= {sample_q, sample_i};
				for (int k = 1; k < TAPS_PER_ARM; k++) begin
					hist_q[k] <= hist_q[k-1];
				end
			end
			if (skip_dec) begin
				skip_q <= skip_q - 6'd1;
			end
			if (state_q == ST_MAC) begin
				pos_q <= pos_q + POS_W'(1);
			end else begin
				pos_q <= '0;
			end
			if (load_out) begin
				out_valid <= 1'b1;
				frac_q    <= nxt_frac_q;
				arm_idx_q <= nxt_idx_q[ARM_W-1:0];
				if (last_q) begin
					skip_q <= 6'(nxt_idx_q / ARMS) - 6'd1;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start_run) state_d = ST_MAC;
			ST_MAC:  if (pos_q == POS_W'(TAPS_PER_ARM - 1)) state_d = ST_DRN1;
			ST_DRN1: state_d = ST_DRN2;
			ST_DRN2: state_d = ST_FIN1;
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: if (load_out) state_d = last_q ? ST_IDLE : ST_MAC;
			default: state_d = ST_IDLE;
		endcase
	end

	assign mac_ctl.vld = (state_q == ST_MAC);
	assign mac_ctl.clr = start_run || (load_out && !last_q);
	assign rd_addr = {arm_idx_q, pos_q};

	always_ff @(posedge clk) begin
		if (acc_in && (kind_t'(kind) == KIND_ARM)) begin
			arm_mem[tap_index[TADDR_W-1:0]] <= tap_value;
		end
		ta_s1 <= arm_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (acc_in && (kind_t'(kind) == KIND_SLOPE)) begin
			slope_mem[tap_index[TADDR_W-1:0]] <= tap_value;
		end
		ts_s1 <= slope_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		hx_s1 <= hist_q[pos_q];
		if (state_q == ST_FIN1) begin
			lo_i_q     <= $signed({1'b0, acc_si[17:0]}) * $signed({1'b0, frac_q});
			lo_q_q     <= $signed({1'b0, acc_sq[17:0]}) * $signed({1'b0, frac_q});
			hi_i_q     <= $signed(acc_si[ACC_W-1:18]) * $signed({1'b0, frac_q});
			hi_q_q     <= $signed(acc_sq[ACC_W-1:18]) * $signed({1'b0, frac_q});
			nxt_idx_q  <= nxt_idx;
			nxt_frac_q <= frac_sum[15:0];
			last_q     <= (nxt_idx >= IDX_W'(ARMS));
		end
		if (load_out) begin
			out_i    <= r_i;
			out_q    <= r_q;
			run_last <= last_q;
		end
	end

	assign y_i = (Y_W'(acc_ai) <<< 16) + Y_W'(lo_i_q) + (Y_W'(hi_i_q) <<< 18);
	assign y_q = (Y_W'(acc_aq) <<< 16) + Y_W'(lo_q_q) + (Y_W'(hi_q_q) <<< 18);
	assign r_i = rnd_sat(y_i);
	assign r_q = rnd_sat(y_q);

	pfar_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.x_i    ($signed(hx_s1[15:0])),
		.x_q    ($signed(hx_s1[31:16])),
		.ta     ($signed(ta_s1)),
		.ts     ($signed(ts_s1)),
		.acc_ai (acc_ai),
		.acc_aq (acc_aq),
		.acc_si (acc_si),
		.acc_sq (acc_sq),
		.busy   (mac_busy)
	);

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN1) |-> !mac_busy)
		else $error("combine started before MAC drained");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && last_q) |=> (state_q == ST_IDLE))
		else $error("run did not end after last beat");
	a_mac_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC && pos_q == POS_W'(TAPS_PER_ARM - 1)) |=> (state_q == ST_DRN1))
		else $error("MAC pass length wrong");
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input taken while busy");
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the polyphase arbitrary resampler core.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pfar_pkg::*;

	typedef struct {
		logic signed [15:0] i;
		logic signed [15:0] q;
		logic               last;
	} resamp_out_t;

	typedef struct {
		kind_t              k;
		logic signed [15:0] si;
		logic signed [15:0] sq;
		logic [9:0]         idx;
		logic signed [15:0] val;
		bit                 typed;
		logic signed [15:0] ei;
		logic signed [15:0] eq;
	} stim_row_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire logic [31:0] prdata;
	wire logic pready;
	logic in_valid = 0;
	wire logic in_ready;
	logic [1:0] kind = '0;
	logic signed [15:0] sample_i = '0, sample_q = '0, tap_value = '0;
	logic [9:0] tap_index = '0;
	wire logic out_valid;
	logic out_ready = 0;
	wire logic signed [15:0] out_i, out_q;
	wire logic run_last;

	polyphase_arbitrary_resampler_core i_dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic signed [15:0] hist_i [TAPS_PER_ARM];
	logic signed [15:0] hist_q [TAPS_PER_ARM];
	logic signed [15:0] arm_coef [TAP_WORDS];
	logic signed [15:0] slope_coef [TAP_WORDS];
	int unsigned cur_arm, cur_frac, samples_to_skip;
	int unsigned dec_step_r, frac_step_r;
	resamp_out_t pending_outs[$];

	int mismatches = 0;
	int send_idle_pct = 0, recv_idle_pct = 0;
	int hold_req = 0, hold_seen = 0, hold_left = 0;

	function automatic logic signed [15:0] round_sat(longint y);
		longint r;
		r = (y + (64'sd1 <<< 30)) >>> 31;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic void resample_predict(kind_t k, logic signed [15:0] si,
			logic signed [15:0] sq, logic [9:0] idx, logic signed [15:0] val);
		int unsigned step, adv, base;
		int cnt;
		longint ai, aq, di, dq;
		resamp_out_t r;
		cnt = 0;
		if (k == KIND_ARM) begin
			arm_coef[idx] = val;
			return;
		end
		if (k == KIND_SLOPE) begin
			slope_coef[idx] = val;
			return;
		end
		if (k != KIND_SAMPLE) return;
		for (int p = TAPS_PER_ARM - 1; p > 0; p--) begin
			hist_i[p] = hist_i[p-1];
			hist_q[p] = hist_q[p-1];
		end
		hist_i[0] = si;
		hist_q[0] = sq;
		if (samples_to_skip > 0) begin
			samples_to_skip--;
			return;
		end
		step = (dec_step_r == 0) ? 1 : dec_step_r;
		while (cur_arm < ARMS) begin
			ai = 0; aq = 0; di = 0; dq = 0;
			base = cur_arm * TAPS_PER_ARM;
			for (int p = 0; p < TAPS_PER_ARM; p++) begin
				ai += longint'(hist_i[p]) * longint'(arm_coef[base+p]);
				aq += longint'(hist_q[p]) * longint'(arm_coef[base+p]);
				di += longint'(hist_i[p]) * longint'(slope_coef[base+p]);
				dq += longint'(hist_q[p]) * longint'(slope_coef[base+p]);
			end
			if (cnt < 32) begin
				r.i = round_sat(ai * 65536 + di * longint'(cur_frac));
				r.q = round_sat(aq * 65536 + dq * longint'(cur_frac));
				r.last = 0;
				pending_outs.push_back(r);
				cnt++;
			end
			cur_frac += frac_step_r;
			cur_arm += step + (cur_frac >> 16);
			cur_frac &= 16'hFFFF;
		end
		adv = cur_arm / ARMS;
		cur_arm = cur_arm % ARMS;
		samples_to_skip = (adv - 1) & 6'h3F;
		if (cnt > 0) pending_outs[pending_outs.size()-1].last = 1;
	endfunction

	task automatic send_beat(kind_t k, logic signed [15:0] si, logic signed [15:0] sq,
			logic [9:0] idx, logic signed [15:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		sample_i <= si;
		sample_q <= sq;
		tap_index <= idx;
		tap_value <= val;
		do @(posedge clk); while (!in_ready);
		resample_predict(k, si, sq, idx, val);
	endtask

	task automatic reg_write(reg_idx_t r, int unsigned v);
		in_valid <= 0;
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 4'(4 * int'(r));
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		case (r)
			REG_DEC_STEP: dec_step_r = v & 6'h3F;
			REG_FRAC_STEP: frac_step_r = v & 16'hFFFF;
			REG_START_ARM: begin
				cur_arm = v & 5'h1F;
				samples_to_skip = 0;
			end
			REG_START_FRAC: cur_frac = v & 16'hFFFF;
		endcase
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (pending_outs.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic load_all_taps(bit zero);
		logic signed [15:0] v;
		for (int n = 0; n < 2 * TAP_WORDS; n++) begin
			v = zero ? 16'sd0 : ($signed(16'($urandom)) >>> $urandom_range(0, 6));
			send_beat(n < TAP_WORDS ? KIND_ARM : KIND_SLOPE, 16'($urandom),
				16'($urandom), 10'(n % TAP_WORDS), v);
		end
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		resamp_out_t e;
		if (out_valid && out_ready) begin
			if (pending_outs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: i=%0d q=%0d last=%0d", out_i, out_q, run_last);
			end else begin
				e = pending_outs.pop_front();
				if (out_i !== e.i || out_q !== e.q || run_last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp i=%0d q=%0d last=%0d got i=%0d q=%0d last=%0d",
							e.i, e.q, e.last, out_i, out_q, run_last);
				end
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	stim_row_t directed[] = '{
		'{KIND_SAMPLE, 16'sd0, 16'sd0, 10'd0, 16'sd0, 1, 16'sd0, 16'sd0},
		'{KIND_NONE, 16'sh7FFF, 16'sh8000, 10'h3FF, 16'sh7FFF, 0, 0, 0},
		'{KIND_ARM, 16'sd0, 16'sd0, 10'd0, 16'sh8000, 0, 0, 0},
		'{KIND_SLOPE, 16'sd0, 16'sd0, 10'd0, 16'sh7FFF, 0, 0, 0},
		'{KIND_ARM, 16'sd0, 16'sd0, 10'h3FF, 16'sh7FFF, 0, 0, 0},
		'{KIND_SLOPE, 16'sd0, 16'sd0, 10'h3FF, 16'sh8000, 0, 0, 0},
		'{KIND_SAMPLE, 16'sh8000, 16'sh8000, 10'd0, 16'sd0, 1, 16'sh7FFF, 16'sh7FFF},
		'{KIND_SAMPLE, 16'sh7FFF, 16'sh8000, 10'd0, 16'sd0, 0, 0, 0},
		'{KIND_SAMPLE, 16'sd0, 16'sh7FFF, 10'd0, 16'sd0, 0, 0, 0},
		'{KIND_ARM, 16'sd0, 16'sd0, 10'd31, 16'sh4000, 0, 0, 0},
		'{KIND_SLOPE, 16'sd0, 16'sd0, 10'd992, 16'sh7FFF, 0, 0, 0},
		'{KIND_SAMPLE, 16'sh7FFF, 16'sh7FFF, 10'd0, 16'sd0, 0, 0, 0},
		'{KIND_NONE, 16'sd0, 16'sd0, 10'd0, 16'sd0, 0, 0, 0},
		'{KIND_SAMPLE, -16'sd1, 16'sd1, 10'h2AA, 16'sh5555, 0, 0, 0},
		'{KIND_SAMPLE, 16'sh8000, 16'sh7FFF, 10'h155, 16'shAAAA, 0, 0, 0}
	};

	int unsigned phase_cfg [7][4] = '{
		'{2, 32768, 5, 65535},
		'{0, 65535, 31, 1},
		'{63, 65535, 31, 65535},
		'{16, 12345, 7, 0},
		'{1, 0, 0, 0},
		'{32, 0, 0, 0},
		'{1, 65535, 0, 65535}
	};

	initial begin
		int roll, before_sz;
		send_idle_pct = 33;
		recv_idle_pct = 82;
		dec_step_r = 1;
		frac_step_r = 0;
		cur_arm = 0;
		cur_frac = 0;
		samples_to_skip = 0;
		for (int p = 0; p < TAPS_PER_ARM; p++) begin
			hist_i[p] = 0;
			hist_q[p] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		load_all_taps(1);
		foreach (directed[n]) begin
			before_sz = pending_outs.size();
			send_beat(directed[n].k, directed[n].si, directed[n].sq, directed[n].idx,
				directed[n].val);
			if (directed[n].typed) begin
				pending_outs[before_sz].i = directed[n].ei;
				pending_outs[before_sz].q = directed[n].eq;
			end
		end
		wait_drained();
		load_all_taps(0);
		for (int ph = 0; ph < 7; ph++) begin
			wait_drained();
			if (ph == 3) begin
				send_idle_pct = 82;
				recv_idle_pct = 33;
			end
			if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			reg_write(REG_DEC_STEP, phase_cfg[ph][0]);
			reg_write(REG_FRAC_STEP, phase_cfg[ph][1]);
			reg_write(REG_START_ARM, phase_cfg[ph][2]);
			reg_write(REG_START_FRAC, phase_cfg[ph][3]);
			if (ph == 4) hold_req++;
			for (int n = 0; n < 33; n++) begin
				roll = $urandom_range(99);
				if (roll < 85)
					send_beat(KIND_SAMPLE, rand_sample(), rand_sample(), 10'($urandom),
						16'($urandom));
				else if (roll < 93)
					send_beat(roll[0] ? KIND_ARM : KIND_SLOPE, 16'($urandom),
						16'($urandom), 10'($urandom), $signed(16'($urandom)) >>> 3);
				else
					send_beat(KIND_NONE, 16'($urandom), 16'($urandom), 10'($urandom),
						16'($urandom));
			end
		end
		wait_drained();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
